@@ design/sha512_hash_engine_unit_macros.svh @@
// Assertion macros shared by the SHA-512 engine RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef SHA512_HASH_ENGINE_UNIT_MACROS_SVH
`define SHA512_HASH_ENGINE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SHA512_ASSERT_IMP(lbl, ante, cons) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |-> (cons)) else $error("sha512 check failed");
`define SHA512_ASSERT_NXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |=> (cons)) else $error("sha512 check failed");
`else
`define SHA512_ASSERT_IMP(lbl, ante, cons)
`define SHA512_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ design/sha512_pkg.sv @@
// Shared types, constants and round functions for the SHA-512 engine.
// No dependencies.
package sha512_pkg;

	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [3:0] LEN_HI_SLOT = 4'd14;
	localparam logic [3:0] LAST_SLOT = 4'd15;
	localparam logic [2:0] LAST_DIGEST = 3'd7;
	localparam logic [63:0] MARK_WORD = 64'h8000_0000_0000_0000;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [3:0] FULL_BYTES = 4'd8;

	localparam logic [63:0] INIT_HASH [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	// one queued beat, already classified by the front end
	typedef struct packed {
		logic [63:0] word;  // data with padding byte merged on a partial last word
		logic [6:0]  bits;  // message bits this beat adds
		logic        last;
		logic        full;  // set unless a last word holds under 8 bytes: marker word still to push
	} item_t;

	typedef enum logic [2:0] {ST_IDLE, ST_PUSH, ST_COMP, ST_FINAL, ST_OUT} state_t;
	typedef enum logic [1:0] {PH_MARK, PH_PAD, PH_LENL} phase_t;

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] bsig0(input logic [63:0] x);
		bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic logic [63:0] bsig1(input logic [63:0] x);
		bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

	function automatic logic [63:0] ssig0(input logic [63:0] x);
		ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic logic [63:0] ssig1(input logic [63:0] x);
		ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic logic [63:0] round_k(input logic [6:0] r);
		case (r)
			7'd0:  round_k = 64'h428a2f98d728ae22; 7'd1:  round_k = 64'h7137449123ef65cd;
			7'd2:  round_k = 64'hb5c0fbcfec4d3b2f; 7'd3:  round_k = 64'he9b5dba58189dbbc;
			7'd4:  round_k = 64'h3956c25bf348b538; 7'd5:  round_k = 64'h59f111f1b605d019;
			7'd6:  round_k = 64'h923f82a4af194f9b; 7'd7:  round_k = 64'hab1c5ed5da6d8118;
			7'd8:  round_k = 64'hd807aa98a3030242; 7'd9:  round_k = 64'h12835b0145706fbe;
			7'd10: round_k = 64'h243185be4ee4b28c; 7'd11: round_k = 64'h550c7dc3d5ffb4e2;
			7'd12: round_k = 64'h72be5d74f27b896f; 7'd13: round_k = 64'h80deb1fe3b1696b1;
			7'd14: round_k = 64'h9bdc06a725c71235; 7'd15: round_k = 64'hc19bf174cf692694;
			7'd16: round_k = 64'he49b69c19ef14ad2; 7'd17: round_k = 64'hefbe4786384f25e3;
			7'd18: round_k = 64'h0fc19dc68b8cd5b5; 7'd19: round_k = 64'h240ca1cc77ac9c65;
			7'd20: round_k = 64'h2de92c6f592b0275; 7'd21: round_k = 64'h4a7484aa6ea6e483;
			7'd22: round_k = 64'h5cb0a9dcbd41fbd4; 7'd23: round_k = 64'h76f988da831153b5;
			7'd24: round_k = 64'h983e5152ee66dfab; 7'd25: round_k = 64'ha831c66d2db43210;
			7'd26: round_k = 64'hb00327c898fb213f; 7'd27: round_k = 64'hbf597fc7beef0ee4;
			7'd28: round_k = 64'hc6e00bf33da88fc2; 7'd29: round_k = 64'hd5a79147930aa725;
			7'd30: round_k = 64'h06ca6351e003826f; 7'd31: round_k = 64'h142929670a0e6e70;
			7'd32: round_k = 64'h27b70a8546d22ffc; 7'd33: round_k = 64'h2e1b21385c26c926;
			7'd34: round_k = 64'h4d2c6dfc5ac42aed; 7'd35: round_k = 64'h53380d139d95b3df;
			7'd36: round_k = 64'h650a73548baf63de; 7'd37: round_k = 64'h766a0abb3c77b2a8;
			7'd38: round_k = 64'h81c2c92e47edaee6; 7'd39: round_k = 64'h92722c851482353b;
			7'd40: round_k = 64'ha2bfe8a14cf10364; 7'd41: round_k = 64'ha81a664bbc423001;
			7'd42: round_k = 64'hc24b8b70d0f89791; 7'd43: round_k = 64'hc76c51a30654be30;
			7'd44: round_k = 64'hd192e819d6ef5218; 7'd45: round_k = 64'hd69906245565a910;
			7'd46: round_k = 64'hf40e35855771202a; 7'd47: round_k = 64'h106aa07032bbd1b8;
			7'd48: round_k = 64'h19a4c116b8d2d0c8; 7'd49: round_k = 64'h1e376c085141ab53;
			7'd50: round_k = 64'h2748774cdf8eeb99; 7'd51: round_k = 64'h34b0bcb5e19b48a8;
			7'd52: round_k = 64'h391c0cb3c5c95a63; 7'd53: round_k = 64'h4ed8aa4ae3418acb;
			7'd54: round_k = 64'h5b9cca4f7763e373; 7'd55: round_k = 64'h682e6ff3d6b2b8a3;
			7'd56: round_k = 64'h748f82ee5defb2fc; 7'd57: round_k = 64'h78a5636f43172f60;
			7'd58: round_k = 64'h84c87814a1f0ab72; 7'd59: round_k = 64'h8cc702081a6439ec;
			7'd60: round_k = 64'h90befffa23631e28; 7'd61: round_k = 64'ha4506cebde82bde9;
			7'd62: round_k = 64'hbef9a3f7b2c67915; 7'd63: round_k = 64'hc67178f2e372532b;
			7'd64: round_k = 64'hca273eceea26619c; 7'd65: round_k = 64'hd186b8c721c0c207;
			7'd66: round_k = 64'heada7dd6cde0eb1e; 7'd67: round_k = 64'hf57d4f7fee6ed178;
			7'd68: round_k = 64'h06f067aa72176fba; 7'd69: round_k = 64'h0a637dc5a2c898a6;
			7'd70: round_k = 64'h113f9804bef90dae; 7'd71: round_k = 64'h1b710b35131c471b;
			7'd72: round_k = 64'h28db77f523047d84; 7'd73: round_k = 64'h32caab7b40c72493;
			7'd74: round_k = 64'h3c9ebe0a15c9bebc; 7'd75: round_k = 64'h431d67c49c100d4c;
			7'd76: round_k = 64'h4cc5d4becb3e42b6; 7'd77: round_k = 64'h597f299cfc657e2a;
			7'd78: round_k = 64'h5fcb6fab3ad6faec; 7'd79: round_k = 64'h6c44198c4a475817;
			default: round_k = '0;
		endcase
	endfunction

endpackage

@@ design/sha512_front.sv @@
// Front end of the SHA-512 engine: classifies input beats and queues them.
// Depends on sha512_pkg.
module sha512_front import sha512_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] msg_word,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	output item_t       item,
	output logic        item_valid,
	input  logic        item_pop
);

	item_t      cls;
	item_t      q_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic [3:0] nbytes;
	logic       push;

	// saturate count, trim partial word and merge the 0x80 pad byte
	always_comb begin
		nbytes = (byte_count > FULL_BYTES) ? FULL_BYTES : byte_count;
		cls.last = last_word;
		cls.full = !last_word || (nbytes == FULL_BYTES);
		cls.bits = last_word ? {nbytes, 3'b000} : 7'd64;
		cls.word = msg_word;
		if (last_word && nbytes != FULL_BYTES) begin
			for (int i = 0; i < 8; i++) begin
				if (4'(i) < nbytes)
					cls.word[63-8*i -: 8] = msg_word[63-8*i -: 8];
				else if (4'(i) == nbytes)
					cls.word[63-8*i -: 8] = PAD_BYTE;
				else
					cls.word[63-8*i -: 8] = 8'h00;
			end
		end
	end

	assign in_stall = cnt_q[1];
	assign push = in_valid && !in_stall;
	assign item_valid = (cnt_q != 2'd0);
	assign item = q_q[rd_q];

	// two-entry queue between front and back
	always_ff @(posedge clk) begin
		if (push)
			q_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (item_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, item_pop};
		end
	end

endmodule

@@ design/sha512_back.sv @@
// Back end of the SHA-512 engine: block fill, padding, 80-round compression, digest output.
// Depends on sha512_pkg and sha512_hash_engine_unit_macros.svh.
`include "sha512_hash_engine_unit_macros.svh"
module sha512_back import sha512_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        item_valid,
	output logic        item_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        digest_last
);

	state_t      state_q, state_d, ret_q, ret_d;
	phase_t      phase_q, phase_d;
	logic [3:0]  fill_q;
	logic [6:0]  round_q;
	logic [2:0]  oidx_q;
	logic [63:0] hash_q [8];
	logic [63:0] v_q [8];
	logic [63:0] w_q [16];
	logic [63:0] len_lo_q, len_hi_q;
	logic        out_valid_q;
	logic [63:0] digest_word_q;
	logic [2:0]  digest_index_q;
	logic        digest_last_q;

	logic        wr_en, wrap, emit;
	logic [63:0] wr_word;
	logic [63:0] t1, t2, w_new;
	logic [64:0] lo_sum;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (fill_q == LAST_SLOT)
						state_d = ST_COMP;
					else if (item.last)
						state_d = ST_PUSH;
				end
			end
			ST_PUSH:  if (fill_q == LAST_SLOT) state_d = ST_COMP;
			ST_COMP:  if (round_q == LAST_ROUND) state_d = ST_FINAL;
			ST_FINAL: state_d = ret_q;
			ST_OUT:   if (emit && oidx_q == LAST_DIGEST) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		item_pop = (state_q == ST_IDLE) && item_valid;
		wr_en = item_pop || (state_q == ST_PUSH);
		wrap = wr_en && (fill_q == LAST_SLOT);
		emit = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
		wr_word = '0;
		phase_d = phase_q;
		ret_d = ST_IDLE;
		if (item_pop) begin
			wr_word = item.word;
			phase_d = item.full ? PH_MARK : PH_PAD;
			ret_d = item.last ? ST_PUSH : ST_IDLE;
		end else begin
			unique case (phase_q)
				PH_MARK: begin
					wr_word = MARK_WORD;
					phase_d = PH_PAD;
				end
				PH_PAD: begin
					if (fill_q == LEN_HI_SLOT) begin
						wr_word = len_hi_q;
						phase_d = PH_LENL;
					end
				end
				PH_LENL: begin
					wr_word = len_lo_q;
					phase_d = PH_PAD;
				end
				default: phase_d = PH_PAD;
			endcase
			ret_d = (phase_q == PH_LENL) ? ST_OUT : ST_PUSH;
		end
	end

	// round datapath
	always_comb begin
		t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ round_k(round_q) + w_q[0];
		t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
		lo_sum = {1'b0, len_lo_q} + {58'd0, item.bits};
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			phase_q <= PH_PAD;
			fill_q <= '0;
			round_q <= '0;
			oidx_q <= '0;
			out_valid_q <= 1'b0;
			len_lo_q <= '0;
			len_hi_q <= '0;
			hash_q <= INIT_HASH;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				fill_q <= fill_q + 4'd1;
				phase_q <= phase_d;
			end
			if (wrap) begin
				ret_q <= ret_d;
				round_q <= '0;
			end else if (state_q == ST_COMP) begin
				round_q <= round_q + 7'd1;
			end
			if (item_pop) begin
				len_lo_q <= lo_sum[63:0];
				len_hi_q <= len_hi_q + {63'd0, lo_sum[64]};
			end
			if (state_q == ST_FINAL) begin
				for (int i = 0; i < 8; i++)
					hash_q[i] <= hash_q[i] + v_q[i];
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == LAST_DIGEST) begin
					hash_q <= INIT_HASH;
					len_lo_q <= '0;
					len_hi_q <= '0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// block buffer, working variables and digest register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			w_q[fill_q] <= wr_word;
		end else if (state_q == ST_COMP) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end
		if (wrap) begin
			v_q <= hash_q;
		end else if (state_q == ST_COMP) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (emit) begin
			digest_word_q <= hash_q[oidx_q];
			digest_index_q <= oidx_q;
			digest_last_q <= (oidx_q == LAST_DIGEST);
		end
	end

	assign out_valid = out_valid_q;
	assign digest_word = digest_word_q;
	assign digest_index = digest_index_q;
	assign digest_last = digest_last_q;

	`SHA512_ASSERT_IMP(a_last_index, out_valid_q && digest_last_q, digest_index_q == LAST_DIGEST)
	`SHA512_ASSERT_IMP(a_comp_empty, state_q == ST_COMP, fill_q == 4'd0)
	`SHA512_ASSERT_NXT(a_round_end, state_q == ST_COMP && round_q == LAST_ROUND, state_q == ST_FINAL)
	`SHA512_ASSERT_IMP(a_out_clean, state_q == ST_OUT, fill_q == 4'd0 && !item_pop)

endmodule

@@ design/sha512_hash_engine_unit.sv @@
// SHA-512 engine. Message words enter as 64-bit beats, first byte in bits 63:56; a beat with
// last_word set ends the message and may hold 0 to 8 bytes (counts above 8 read as 8). A word
// that is not last is written to the block buffer; every sixteenth word starts a compression
// (working variables loaded as that word is written, 80 rounds of the single round unit, one
// hash update). The last word adds padding pushes (marker, zero and length words), one or two
// compressions, then eight digest beats, word 0 first. A two-entry queue in front of the
// sequencer accepts up to two beats while a compression runs; an output register holds each
// digest beat until it is taken. The round unit bounds throughput. No reset sweep is needed.
module sha512_hash_engine_unit import sha512_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] msg_word,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        digest_last
);

	item_t item;
	logic  item_valid;
	logic  item_pop;

	// classify and queue input beats
	sha512_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.msg_word   (msg_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop)
	);

	// fill, pad, compress and emit
	sha512_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_pop     (item_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_word  (digest_word),
		.digest_index (digest_index),
		.digest_last  (digest_last)
	);

endmodule
